// File: src/rewc_pkg.sv
package rewc_pkg;

  // Default envelope lengths, in ticks.
  localparam int unsigned ATTACK_STEPS_DEF = 8;
  localparam int unsigned DECAY_STEPS_DEF  = 20;

  // Fixed widths. The step counter wraps at 5 bits, so phase lengths stay
  // at or below 31 and their squares fit in 10 bits.
  localparam int STEP_W    = 5;
  localparam int DEN_W     = 10;
  localparam int NUM_W     = 18;
  localparam int QUO_W     = 8;
  localparam int CNT_W     = 3;
  localparam int HW_PROD_W = 30;
  localparam int MIX_W     = 14;
  localparam int SCL_PROD_W = 31;
  localparam int RECIP_SHIFT = 24;

  // Envelope division by reciprocal: quotient = (num * recip) >> DIV_SHIFT.
  // With a dividend below 2**NUM_W and a denominator below 2**DEN_W the
  // rounded-up reciprocal gives the exact floor.
  localparam int RECIP_W   = 29;
  localparam int DIV_SHIFT = 28;

  // Sequencer counts.
  localparam int DIV_ITERS = 1;
  localparam int NUM_CHAN  = 3;

  // Reciprocals for exact division by 255 over the value ranges used here.
  localparam logic [16:0] DIV255_RECIP = 17'd65794;
  // 61 * DIV255_RECIP, for the half-width scaling.
  localparam logic [21:0] HW_RECIP = 22'd4013434;

  // Input item kinds.
  localparam logic FUNC_EVENT = 1'b0;
  localparam logic FUNC_TICK  = 1'b1;

  // Colour channel selects.
  localparam logic [1:0] CH_RED   = 2'd0;
  localparam logic [1:0] CH_GREEN = 2'd1;
  localparam logic [1:0] CH_BLUE  = 2'd2;

  // Palette entry used at full level.
  localparam logic [3:0] PAL_LAST = 4'd8;

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_ATTACK  = 2'd1,
    PH_SUSTAIN = 2'd2,
    PH_DECAY   = 2'd3
  } rewc_phase_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       ev_apply;
    logic       tick_load;
    logic       sq_en;
    logic       mul_en;
    logic       div_step;
    logic       env_en;
    logic       hw_en;
    logic       mix_en;
    logic [1:0] mix_ch;
    logic       scale_en;
    logic [1:0] scale_ch;
    logic       out_load;
  } rewc_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic div_path;
  } rewc_sts_t;

  // floor(x * 255 / 25) for x in 1..24.
  function automatic logic [7:0] norm_lut(input logic [4:0] x);
    logic [7:0] v;
    unique case (x)
      5'd1:    v = 8'd10;
      5'd2:    v = 8'd20;
      5'd3:    v = 8'd30;
      5'd4:    v = 8'd40;
      5'd5:    v = 8'd51;
      5'd6:    v = 8'd61;
      5'd7:    v = 8'd71;
      5'd8:    v = 8'd81;
      5'd9:    v = 8'd91;
      5'd10:   v = 8'd102;
      5'd11:   v = 8'd112;
      5'd12:   v = 8'd122;
      5'd13:   v = 8'd132;
      5'd14:   v = 8'd142;
      5'd15:   v = 8'd153;
      5'd16:   v = 8'd163;
      5'd17:   v = 8'd173;
      5'd18:   v = 8'd183;
      5'd19:   v = 8'd193;
      5'd20:   v = 8'd204;
      5'd21:   v = 8'd214;
      5'd22:   v = 8'd224;
      5'd23:   v = 8'd234;
      5'd24:   v = 8'd244;
      default: v = 8'd0;
    endcase
    return v;
  endfunction

  // Nine-entry waterfall palette in RGB565.
  function automatic logic [15:0] palette_color(input logic [3:0] idx);
    logic [15:0] c;
    unique case (idx)
      4'd0:    c = 16'h000F;
      4'd1:    c = 16'h001F;
      4'd2:    c = 16'h043F;
      4'd3:    c = 16'h07FF;
      4'd4:    c = 16'h07E0;
      4'd5:    c = 16'h8FE0;
      4'd6:    c = 16'hFFE0;
      4'd7:    c = 16'hFD00;
      4'd8:    c = 16'hF800;
      default: c = 16'h0000;
    endcase
    return c;
  endfunction

endpackage

// File: src/rewc_div.sv
// Division by a phase denominator through its rounded-up reciprocal.
// The dividend and reciprocal are registered on load, the quotient on step.
// The caller guarantees num_i < 2**QUO_W times the denominator.
module rewc_div import rewc_pkg::*; (
  input  logic               clk_i,
  input  logic               load_i,
  input  logic               step_i,
  input  logic [NUM_W-1:0]   num_i,
  input  logic [RECIP_W-1:0] recip_i,
  output logic [QUO_W-1:0]   quo_o
);

  localparam int PROD_W = NUM_W + RECIP_W;

  logic [NUM_W-1:0]   num_q;
  logic [RECIP_W-1:0] recip_q;
  logic [QUO_W-1:0]   quo_q;
  logic [PROD_W-1:0]  prod;

  assign prod = PROD_W'(num_q) * PROD_W'(recip_q);

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      num_q   <= num_i;
      recip_q <= recip_i;
    end
    if (step_i) begin
      quo_q <= prod[DIV_SHIFT+QUO_W-1:DIV_SHIFT];
    end
  end

  assign quo_o = quo_q;

endmodule

// File: src/rewc_datapath.sv
// Envelope state, arithmetic and result registers.
module rewc_datapath import rewc_pkg::*; #(
  parameter int unsigned ATTACK_STEPS = ATTACK_STEPS_DEF,
  parameter int unsigned DECAY_STEPS  = DECAY_STEPS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic              cfg_wdata_i,
  input  logic signed [8:0] rssi_dbm_i,
  input  rewc_cmd_t         cmd_i,
  output rewc_sts_t         sts_o,
  output logic [7:0]        level_o,
  output logic [5:0]        half_width_o,
  output logic [15:0]       color_rgb565_o,
  output logic              blank_o,
  output logic [1:0]        env_phase_o,
  output logic [31:0]       signal_count_o
);

  localparam logic [STEP_W-1:0] AttackLen = STEP_W'(ATTACK_STEPS);
  localparam logic [STEP_W-1:0] DecayLen  = STEP_W'(DECAY_STEPS);
  localparam logic [DEN_W-1:0]  DenDecay  = DEN_W'(DECAY_STEPS * DECAY_STEPS);
  // Rounded-up reciprocals of the attack and decay denominators.
  localparam logic [RECIP_W-1:0] RecipAttack =
    RECIP_W'(((64'd1 << DIV_SHIFT) + ATTACK_STEPS * ATTACK_STEPS - 1)
             / (ATTACK_STEPS * ATTACK_STEPS));
  localparam logic [RECIP_W-1:0] RecipDecay =
    RECIP_W'(((64'd1 << DIV_SHIFT) + DECAY_STEPS * DECAY_STEPS - 1)
             / (DECAY_STEPS * DECAY_STEPS));

  // Control state.
  logic              radio_ready_q;
  rewc_phase_e       phase_q, phase_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic              active_q, active_d;
  logic [31:0]       total_q, total_d;

  // Working registers.
  logic [7:0]        base_q;
  logic [DEN_W-1:0]  sq_q;
  logic [7:0]        lvl_q;
  logic [5:0]        hw_q;
  logic [3:0]        idx_q;
  logic [7:0]        r_q;
  logic [MIX_W-1:0]  mix_q;
  logic [15:0]       col_q;

  // Result registers.
  logic [7:0]        level_out_q;
  logic [5:0]        hw_out_q;
  logic [15:0]       col_out_q;
  logic              blank_out_q;
  logic [1:0]        phase_out_q;
  logic [31:0]       count_out_q;

  // Normalization of the sample onto 0..255.
  logic signed [9:0] rssi_off;
  logic [7:0]        base_d;

  assign rssi_off = radio_ready_q ? (10'(rssi_dbm_i) + 10'sd45) : 10'sd0;

  always_comb begin
    priority if (rssi_off[9] || (rssi_off == 10'sd0)) begin
      base_d = 8'd0;
    end else if (rssi_off >= 10'sd25) begin
      base_d = 8'd255;
    end else begin
      base_d = norm_lut(rssi_off[4:0]);
    end
  end

  // Squared progress term: s*s in attack, D*D - (D-s)*(D-s) in decay.
  logic              is_decay;
  logic [STEP_W-1:0] decay_pos;
  logic [STEP_W-1:0] sq_op;
  logic [DEN_W-1:0]  sq_prod;
  logic [DEN_W-1:0]  sq_d;

  assign is_decay  = (phase_q == PH_DECAY);
  assign decay_pos = (step_q > DecayLen) ? DecayLen : step_q;
  assign sq_op     = is_decay ? (DecayLen - decay_pos) : step_q;
  assign sq_prod   = DEN_W'(sq_op) * DEN_W'(sq_op);
  assign sq_d      = is_decay ? (DenDecay - sq_prod) : sq_prod;

  // Dividend for the envelope division; decay rounds up.
  logic [7:0]       headroom;
  logic [NUM_W-1:0] num;
  logic [QUO_W-1:0] quo;

  assign headroom = 8'd255 - base_q;
  assign num = (NUM_W'(headroom) * NUM_W'(sq_q))
             + (is_decay ? NUM_W'(DenDecay - DEN_W'(1)) : NUM_W'(0));

  rewc_div u_div (
    .clk_i   (clk_i),
    .load_i  (cmd_i.mul_en),
    .step_i  (cmd_i.div_step),
    .num_i   (num),
    .recip_i (is_decay ? RecipDecay : RecipAttack),
    .quo_o   (quo)
  );

  // Envelope step and event handling.
  logic [8:0]        attack_sum;
  logic [STEP_W-1:0] step_inc;
  logic [7:0]        env;
  logic [7:0]        lvl_d;

  assign attack_sum = {1'b0, base_q} + {1'b0, quo};
  assign step_inc   = step_q + STEP_W'(1);

  always_comb begin
    phase_d  = phase_q;
    step_d   = step_q;
    active_d = active_q;
    total_d  = total_q;
    env      = 8'd0;
    if (cmd_i.ev_apply && radio_ready_q) begin
      total_d  = total_q + 32'd1;
      active_d = 1'b1;
      if ((phase_q == PH_IDLE) || (phase_q == PH_DECAY)) begin
        phase_d = PH_ATTACK;
        step_d  = '0;
      end
    end else if (cmd_i.env_en) begin
      unique case (phase_q)
        PH_IDLE: begin
          env = 8'd0;
        end
        PH_ATTACK: begin
          env = attack_sum[8] ? 8'd255 : attack_sum[7:0];
          step_d = step_inc;
          if (step_inc >= AttackLen) begin
            env      = 8'd255;
            phase_d  = PH_SUSTAIN;
            step_d   = '0;
            active_d = 1'b0;
          end
        end
        PH_SUSTAIN: begin
          env = 8'd255;
          if (!active_q) begin
            phase_d = PH_DECAY;
            step_d  = '0;
          end
          active_d = 1'b0;
        end
        PH_DECAY: begin
          env = 8'd255 - quo;
          step_d = step_inc;
          if (step_inc >= DecayLen) begin
            env     = 8'd0;
            phase_d = PH_IDLE;
            step_d  = '0;
          end
        end
        default: begin
          env = 8'd0;
        end
      endcase
    end
  end

  assign lvl_d = (base_q > env) ? base_q : env;

  // Half-width and palette position from the level.
  logic [HW_PROD_W-1:0] hw_prod;
  logic [10:0]          scaled;
  logic [3:0]           idx_d;
  logic [10:0]          r_full;

  assign hw_prod = HW_PROD_W'(lvl_q) * HW_PROD_W'(HW_RECIP);
  assign scaled  = {lvl_q, 3'b000};

  always_comb begin
    idx_d = 4'd0;
    for (int k = 1; k <= 8; k++) begin
      if (scaled >= 11'(255 * k)) begin
        idx_d = idx_d + 4'd1;
      end
    end
  end

  assign r_full = scaled - (11'({idx_d, 8'b0}) - 11'(idx_d));

  // Channel blend: 255*a + (b-a)*r, then divided by 255.
  logic [15:0]              pal_a, pal_b;
  logic [5:0]               chan_a, chan_b;
  logic signed [6:0]        chan_diff;
  logic signed [15:0]       blend_term;
  logic signed [15:0]       blend_full;
  logic [SCL_PROD_W-1:0]    scale_prod;
  logic [5:0]               chan_val;

  assign pal_a = palette_color(idx_q);
  assign pal_b = palette_color(idx_q + 4'd1);

  always_comb begin
    unique case (cmd_i.mix_ch)
      CH_RED: begin
        chan_a = {1'b0, pal_a[15:11]};
        chan_b = {1'b0, pal_b[15:11]};
      end
      CH_GREEN: begin
        chan_a = pal_a[10:5];
        chan_b = pal_b[10:5];
      end
      CH_BLUE: begin
        chan_a = {1'b0, pal_a[4:0]};
        chan_b = {1'b0, pal_b[4:0]};
      end
      default: begin
        chan_a = 6'd0;
        chan_b = 6'd0;
      end
    endcase
  end

  assign chan_diff  = $signed({1'b0, chan_b}) - $signed({1'b0, chan_a});
  assign blend_term = 16'(chan_diff) * 16'($signed({1'b0, r_q}));
  assign blend_full = $signed(16'({chan_a, 8'b0}) - 16'(chan_a)) + blend_term;
  assign scale_prod = SCL_PROD_W'(mix_q) * SCL_PROD_W'(DIV255_RECIP);
  assign chan_val   = scale_prod[RECIP_SHIFT+5:RECIP_SHIFT];

  // Control state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radio_ready_q <= 1'b0;
      phase_q       <= PH_IDLE;
      step_q        <= '0;
      active_q      <= 1'b0;
      total_q       <= '0;
    end else begin
      if (cfg_we_i) begin
        radio_ready_q <= cfg_wdata_i;
      end
      phase_q  <= phase_d;
      step_q   <= step_d;
      active_q <= active_d;
      total_q  <= total_d;
    end
  end

  // Working and result registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.tick_load) begin
      base_q <= base_d;
    end
    if (cmd_i.sq_en) begin
      sq_q <= sq_d;
    end
    if (cmd_i.env_en) begin
      lvl_q <= lvl_d;
    end
    if (cmd_i.hw_en) begin
      hw_q  <= hw_prod[RECIP_SHIFT+5:RECIP_SHIFT] + 6'd1;
      idx_q <= idx_d;
      r_q   <= r_full[7:0];
    end
    if (cmd_i.mix_en) begin
      mix_q <= blend_full[MIX_W-1:0];
    end
    if (cmd_i.scale_en) begin
      unique case (cmd_i.scale_ch)
        CH_RED:   col_q[15:11] <= chan_val[4:0];
        CH_GREEN: col_q[10:5]  <= chan_val;
        CH_BLUE:  col_q[4:0]   <= chan_val[4:0];
        default:  col_q        <= col_q;
      endcase
    end
    if (cmd_i.out_load) begin
      level_out_q <= lvl_q;
      blank_out_q <= (lvl_q == 8'd0);
      hw_out_q    <= (lvl_q == 8'd0) ? 6'd0 : hw_q;
      if (lvl_q == 8'd0) begin
        col_out_q <= 16'h0000;
      end else if (idx_q == PAL_LAST) begin
        col_out_q <= palette_color(PAL_LAST);
      end else begin
        col_out_q <= col_q;
      end
      phase_out_q <= phase_q;
      count_out_q <= total_q;
    end
  end

  assign sts_o.div_path = (phase_q == PH_ATTACK) || (phase_q == PH_DECAY);

  assign level_o        = level_out_q;
  assign half_width_o   = hw_out_q;
  assign color_rgb565_o = col_out_q;
  assign blank_o        = blank_out_q;
  assign env_phase_o    = phase_out_q;
  assign signal_count_o = count_out_q;

endmodule

// File: src/rewc_ctrl.sv
// Sequencer for one tick, plus the input and output handshakes.
module rewc_ctrl import rewc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  logic      func_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  input  rewc_sts_t sts_i,
  output rewc_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SQ,
    S_MUL,
    S_DIV,
    S_ENV,
    S_HW,
    S_COL,
    S_OUT
  } state_e;

  localparam logic [CNT_W-1:0] DivLast = CNT_W'(DIV_ITERS - 1);
  localparam logic [CNT_W-1:0] ColLast = CNT_W'(NUM_CHAN);

  state_e           state_q;
  logic [CNT_W-1:0] cnt_q;
  logic             out_valid_q;
  logic             accept;

  assign accept     = in_valid_i && (state_q == S_IDLE);
  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    cmd_o           = '0;
    cmd_o.ev_apply  = accept && (func_i == FUNC_EVENT);
    cmd_o.tick_load = accept && (func_i == FUNC_TICK);
    cmd_o.sq_en     = (state_q == S_SQ);
    cmd_o.mul_en    = (state_q == S_MUL);
    cmd_o.div_step  = (state_q == S_DIV);
    cmd_o.env_en    = (state_q == S_ENV);
    cmd_o.hw_en     = (state_q == S_HW);
    cmd_o.mix_en    = (state_q == S_COL) && (cnt_q < ColLast);
    cmd_o.mix_ch    = cnt_q[1:0];
    cmd_o.scale_en  = (state_q == S_COL) && (cnt_q != '0);
    cmd_o.scale_ch  = cnt_q[1:0] - 2'd1;
    cmd_o.out_load  = (state_q == S_OUT) && (!out_valid_q || out_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_o.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (cmd_o.tick_load) begin
            state_q <= sts_i.div_path ? S_SQ : S_ENV;
          end
        end
        S_SQ: begin
          state_q <= S_MUL;
        end
        S_MUL: begin
          state_q <= S_DIV;
          cnt_q   <= '0;
        end
        S_DIV: begin
          if (cnt_q == DivLast) begin
            state_q <= S_ENV;
          end else begin
            cnt_q <= cnt_q + CNT_W'(1);
          end
        end
        S_ENV: begin
          state_q <= S_HW;
        end
        S_HW: begin
          state_q <= S_COL;
          cnt_q   <= '0;
        end
        S_COL: begin
          if (cnt_q == ColLast) begin
            state_q <= S_OUT;
          end else begin
            cnt_q <= cnt_q + CNT_W'(1);
          end
        end
        S_OUT: begin
          if (cmd_o.out_load) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// File: src/rssi_envelope_waterfall_colorizer.sv
// RSSI envelope waterfall colorizer.
// The input channel (in_valid_i/in_ready_o) carries one beat per item: func_i
// selects a signal-detected event or a display tick, and rssi_dbm_i holds the
// sample for a tick. An event is absorbed in the cycle it is accepted and
// produces no output beat. A tick produces exactly one output beat on
// out_valid_o/out_ready_i with the level, half-width, RGB565 colour, blank
// flag, envelope phase and event count.
// While the envelope is attacking or decaying, a tick goes through squaring,
// dividend and a reciprocal multiply for the envelope division before the
// envelope step; while idle or sustaining it goes straight to that step. The
// colour blend works through its three channels, sharing one blend and one
// scaling multiplier. The block works on one tick at a time and takes no new
// item until it is through; events are taken every cycle while it is idle.
// Reset clears the envelope, the event counter, radio_ready and the output
// valid. A stalled receiver holds the result in the output register; the
// block still accepts the next item and finishes it up to the output stage,
// where it waits until the held beat is taken.
// cfg_we_i writes radio_ready from cfg_wdata_i; write it only while idle.
module rssi_envelope_waterfall_colorizer import rewc_pkg::*; #(
  parameter int unsigned ATTACK_STEPS = ATTACK_STEPS_DEF,
  parameter int unsigned DECAY_STEPS  = DECAY_STEPS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic              cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              func_i,
  input  logic signed [8:0] rssi_dbm_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [7:0]        level_o,
  output logic [5:0]        half_width_o,
  output logic [15:0]       color_rgb565_o,
  output logic              blank_o,
  output logic [1:0]        env_phase_o,
  output logic [31:0]       signal_count_o
);

  rewc_cmd_t cmd;
  rewc_sts_t sts;

  // The controller owns both handshakes and steps the datapath one
  // operation per cycle, except while a finished tick waits for the output.
  rewc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .func_i      (func_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // The datapath holds the envelope state, the shared arithmetic and the
  // output register.
  rewc_datapath #(
    .ATTACK_STEPS (ATTACK_STEPS),
    .DECAY_STEPS  (DECAY_STEPS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .rssi_dbm_i     (rssi_dbm_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .level_o        (level_o),
    .half_width_o   (half_width_o),
    .color_rgb565_o (color_rgb565_o),
    .blank_o        (blank_o),
    .env_phase_o    (env_phase_o),
    .signal_count_o (signal_count_o)
  );

endmodule

// File: src/rewc_checker.sv
module rewc_checker import rewc_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input logic              func_i,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input logic [7:0]        level_o,
  input logic [5:0]        half_width_o,
  input logic [15:0]       color_rgb565_o,
  input logic              blank_o
);

  // A held result beat keeps its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(level_o)
      && $stable(color_rgb565_o) && $stable(half_width_o))
    else $error("output beat changed while stalled");

  // The blank flag agrees with the level and zeroes width and colour.
  a_blank: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (blank_o == (level_o == 8'd0))
      && (!blank_o || ((half_width_o == 6'd0) && (color_rgb565_o == 16'h0000))))
    else $error("blank flag inconsistent with result");

  // A drawn line is 1 to 62 pixels wide on each side.
  a_width: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !blank_o |-> (half_width_o != 6'd0) && (half_width_o <= 6'd62))
    else $error("half width out of range");

  // A tick occupies the sequencer, so the input closes right after it.
  a_tick_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (func_i == FUNC_TICK) |=> !in_ready_o)
    else $error("input still open after a tick beat");

endmodule

bind rssi_envelope_waterfall_colorizer rewc_checker u_rewc_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_ready_o     (in_ready_o),
  .func_i         (func_i),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .level_o        (level_o),
  .half_width_o   (half_width_o),
  .color_rgb565_o (color_rgb565_o),
  .blank_o        (blank_o)
);
